@@ hw/rtl/riot_pkg.sv @@
// Shared types and constants for the RIOT timer and ports block.
`timescale 1ns / 1ps
`default_nettype none

package riot_pkg;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_CLOCK     = 3'd2,
    OP_PA_REL    = 3'd3,
    OP_JOY_PRESS = 3'd4,
    OP_PB_REL    = 3'd5,
    OP_RST_SW    = 3'd6,
    OP_SEL_SW    = 3'd7
  } op_e;

  localparam logic [3:0] REG_PA_DATA = 4'd0;
  localparam logic [3:0] REG_PA_DIR  = 4'd1;
  localparam logic [3:0] REG_PB      = 4'd2;
  localparam logic [3:0] REG_TIMER   = 4'd3;
  localparam logic [3:0] REG_TIM1    = 4'd4;
  localparam logic [3:0] REG_TIM8    = 4'd5;
  localparam logic [3:0] REG_TIM64   = 4'd6;
  localparam logic [3:0] REG_TIM1024 = 4'd7;

  localparam logic [7:0]  PA_RELEASED = 8'hFF;
  localparam logic [7:0]  PB_RELEASED = 8'b0000_1011;
  localparam logic [7:0]  UNDECODED   = 8'hFF;

  localparam logic [10:0] IVL_STOP = 11'd0;
  localparam logic [10:0] IVL_1    = 11'd1;
  localparam logic [10:0] IVL_8    = 11'd1 << 3;
  localparam logic [10:0] IVL_64   = 11'd1 << 6;
  localparam logic [10:0] IVL_1024 = 11'd1 << 10;

endpackage

`default_nettype wire

@@ hw/rtl/riot_timer_and_ports.sv @@
// Top level of the RIOT timer and ports block.
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per transfer: a bus
//   read or write, a clock advance, or a controller line change (joystick press,
//   port releases, reset and select switches).
//   Output channel (out_valid_o / out_ready_i) carries exactly one read_data byte
//   per input item, in order; it is zero for every item other than a read.
// Latency: the result of an item is presented the cycle after its transfer.
// Throughput: one item per cycle. All state (ports, timer, prescaler, pending
//   reload) updates at the input transfer; the result lands in a single output
//   register, and a new item is taken whenever that register is empty or is
//   being drained in the same cycle.
// Stall: while the receiver holds out_ready_i low with a result waiting,
//   in_ready_o drops and the result and all state hold.
// Reset: asynchronous, active low. Ports return to released (A = 0xFF,
//   B = 0x0B), the timer is stopped with nothing pending, the zero flag is
//   clear and the output register is empty.
`timescale 1ns / 1ps
`default_nettype none

module riot_timer_and_ports (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] op_i,
  input  wire logic [3:0] reg_req_i,
  input  wire logic [7:0] value_i,
  input  wire logic [2:0] clocks_i,
  input  wire logic [1:0] direction_i,
  input  wire logic       player0_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o
);
  import riot_pkg::*;

  // architectural state
  logic [7:0]  port_a_q, port_a_d;
  logic [7:0]  port_a_dir_q, port_a_dir_d;
  logic [7:0]  port_b_q, port_b_d;
  logic [7:0]  timer_q, timer_d;
  logic [10:0] ivl_q, ivl_d;
  logic [10:0] ivl_left_q, ivl_left_d;
  logic        zero_flag_q, zero_flag_d;
  logic [7:0]  pend_val_q, pend_val_d;
  logic [10:0] pend_ivl_q, pend_ivl_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  rdata_q, rdata_d;

  logic        accept;
  logic [2:0]  joy_bit;
  logic [7:0]  rd_byte;
  op_e         op;

  assign op         = op_e'(op_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign joy_bit    = {player0_i, direction_i};

  // read mux
  always_comb begin
    case (reg_req_i)
      REG_PA_DATA: rd_byte = port_a_q & ~port_a_dir_q;
      REG_PB:      rd_byte = port_b_q;
      REG_TIMER:   rd_byte = timer_q;
      default:     rd_byte = UNDECODED;
    endcase
  end

  // next state of the whole block for the item on the input
  always_comb begin
    port_a_d     = port_a_q;
    port_a_dir_d = port_a_dir_q;
    port_b_d     = port_b_q;
    timer_d      = timer_q;
    ivl_d        = ivl_q;
    ivl_left_d   = ivl_left_q;
    zero_flag_d  = zero_flag_q;
    pend_val_d   = pend_val_q;
    pend_ivl_d   = pend_ivl_q;
    rdata_d      = 8'h00;

    case (op)
      OP_READ: begin
        rdata_d = rd_byte;
        // a timer read clears the zero flag
        if (reg_req_i == REG_TIMER) zero_flag_d = 1'b0;
      end
      OP_WRITE: begin
        case (reg_req_i)
          REG_PA_DIR:  port_a_dir_d = value_i;
          REG_TIM1:    begin pend_val_d = value_i; pend_ivl_d = IVL_1;    end
          REG_TIM8:    begin pend_val_d = value_i; pend_ivl_d = IVL_8;    end
          REG_TIM64:   begin pend_val_d = value_i; pend_ivl_d = IVL_64;   end
          REG_TIM1024: begin pend_val_d = value_i; pend_ivl_d = IVL_1024; end
          default:     ;
        endcase
      end
      OP_CLOCK: begin
        if (ivl_q != IVL_STOP) begin
          if (ivl_q == IVL_1 || zero_flag_q) begin
            // free-running: count down by the clocks, 8-bit wrap
            timer_d = timer_q - {5'd0, clocks_i};
          end else if (ivl_left_q < {8'd0, clocks_i}) begin
            // interval ran out
            if (timer_q == 8'd0) begin
              zero_flag_d = 1'b1;
            end else begin
              timer_d    = timer_q - 8'd1;
              ivl_left_d = ivl_left_q + ivl_q - {8'd0, clocks_i};
            end
          end else begin
            ivl_left_d = ivl_left_q - {8'd0, clocks_i};
          end
        end
        // apply an armed reload after the count; the zero flag stays
        if (pend_ivl_q != IVL_STOP) begin
          timer_d    = pend_val_q;
          ivl_d      = pend_ivl_q;
          ivl_left_d = 11'd0;
          pend_val_d = 8'd0;
          pend_ivl_d = IVL_STOP;
        end
      end
      OP_PA_REL:    port_a_d = PA_RELEASED;
      OP_JOY_PRESS: port_a_d = port_a_q & ~(8'd1 << joy_bit);
      OP_PB_REL:    port_b_d = PB_RELEASED;
      OP_RST_SW:    port_b_d = port_b_q & 8'hFE;
      OP_SEL_SW:    port_b_d = port_b_q & 8'hFD;
      default:      ;
    endcase
  end

  // output register: fill on transfer in, drain on transfer out
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q     <= PA_RELEASED;
      port_a_dir_q <= 8'd0;
      port_b_q     <= PB_RELEASED;
      timer_q      <= 8'd0;
      ivl_q        <= IVL_STOP;
      ivl_left_q   <= 11'd0;
      zero_flag_q  <= 1'b0;
      pend_val_q   <= 8'd0;
      pend_ivl_q   <= IVL_STOP;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        port_a_q     <= port_a_d;
        port_a_dir_q <= port_a_dir_d;
        port_b_q     <= port_b_d;
        timer_q      <= timer_d;
        ivl_q        <= ivl_d;
        ivl_left_q   <= ivl_left_d;
        zero_flag_q  <= zero_flag_d;
        pend_val_q   <= pend_val_d;
        pend_ivl_q   <= pend_ivl_d;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) rdata_q <= rdata_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/riot_checker.sv @@
// Port-level assertions for the RIOT timer and ports block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module riot_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [2:0] op_i,
  input wire logic [3:0] reg_req_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] read_data_o
);
  import riot_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("stalled result changed");

  // no new transfer while a result is stuck in the output register
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken over a stalled result");

  // every non-read item yields a zero byte in the next cycle
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i != OP_READ |=>
      out_valid_o && read_data_o == 8'h00)
    else $error("non-read item gave nonzero data");

  // undecoded reads return all ones
  a_undecoded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_READ &&
    reg_req_i != REG_PA_DATA && reg_req_i != REG_PB && reg_req_i != REG_TIMER |=>
      out_valid_o && read_data_o == UNDECODED)
    else $error("undecoded read not 0xFF");

endmodule

bind riot_timer_and_ports riot_checker u_riot_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .reg_req_i   (reg_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .read_data_o (read_data_o)
);

`default_nettype wire
